// ===== hw/rtl/fwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwt_pkg: shared definitions for the face window tracker
// Register indexes, field widths, reset values and the small remainder tables
// used when the face size is scaled by 2/5 and 9/5.
// ----------------------------------------------------------------------------
package fwt_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Frame size registers
  localparam int FRAME_BITS   = 13;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // Axis slots of the box arrays
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXES   = 2;

  // ceil(2*r/5) for a remainder r of a division by five
  function automatic logic [1:0] rem_ceil_2_5(input logic [2:0] r);
    logic [1:0] v;
    case (r)
      3'd0:    v = 2'd0;
      3'd1:    v = 2'd1;
      3'd2:    v = 2'd1;
      3'd3:    v = 2'd2;
      3'd4:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  // floor(9*r/5) for a remainder r of a division by five
  function automatic logic [2:0] rem_floor_9_5(input logic [2:0] r);
    logic [2:0] v;
    case (r)
      3'd0:    v = 3'd0;
      3'd1:    v = 3'd1;
      3'd2:    v = 3'd3;
      3'd3:    v = 3'd5;
      3'd4:    v = 3'd7;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/face_window_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_window_tracker: per-frame face box smoothing and search window update
// Takes one detection per item, keeps the tracking flag, the shown box and the
// search window, and returns the updated state as one result item.
// ----------------------------------------------------------------------------
// Usage: one detection item is accepted per clock cycle while the result
// register does not stall, and each produces exactly one result item via the
// input register, then the result register that also holds the tracker state.
// The state loop closes at the result register, so back-to-back items see the
// state left by their predecessor. The result register stalls only when
// out_tready is low, and the input register absorbs one more item meanwhile.
// While tracking, face_x/face_y are relative to the last window returned. The
// frame size registers must be written only while no item is in flight.
// ----------------------------------------------------------------------------
module face_window_tracker #(
  parameter int COORD_BITS = fwt_pkg::COORD_BITS_DEF,
  localparam int IN_BITS  = 1 + 4 * COORD_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 + 8 * COORD_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [fwt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fwt_pkg::FRAME_BITS-1:0]    cfg_wdata,
  // Detection items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // face_found, face_x, face_y, face_w, face_h (low to high), zero padded
  input  logic [IN_W-1:0]                   in_tdata,
  // Result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tracking, moved, shown_x, shown_y, shown_w, shown_h,
  // window_x, window_y, window_w, window_h (low to high), zero padded
  output logic [OUT_W-1:0]                  out_tdata
);

  localparam int C    = COORD_BITS;
  localparam int FB   = fwt_pkg::FRAME_BITS;
  localparam int LIMW = FB + C;
  localparam int DIV5_SHIFT = C + 2;
  localparam logic [C-1:0] DIV5_MAGIC = C'(((1 << DIV5_SHIFT) + 4) / 5);
  localparam logic [C-1:0] COORD_MAX  = '1;

  // --------------------------------------------------------------------------
  // Frame size registers and clamp limits
  // --------------------------------------------------------------------------
  logic [FB-1:0] frame_r [fwt_pkg::AXES];
  logic [C-1:0]  lim     [fwt_pkg::AXES];
  logic [FB-1:0] frame_m1[fwt_pkg::AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r[fwt_pkg::AXIS_X] <= fwt_pkg::FRAME_WIDTH_RST;
      frame_r[fwt_pkg::AXIS_Y] <= fwt_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fwt_pkg::CFG_FRAME_WIDTH:  frame_r[fwt_pkg::AXIS_X] <= cfg_wdata;
        fwt_pkg::CFG_FRAME_HEIGHT: frame_r[fwt_pkg::AXIS_Y] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limit is size - 1, zero for a degenerate size, saturated to the coord range
  always_comb begin
    for (int a = 0; a < fwt_pkg::AXES; a++) begin
      frame_m1[a] = (frame_r[a] == '0) ? '0 : frame_r[a] - FB'(1);
      lim[a] = (LIMW'(frame_m1[a]) > LIMW'(COORD_MAX)) ? COORD_MAX : C'(frame_m1[a]);
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic         s1_valid_r;
  logic         s1_found_r;
  logic [C-1:0] s1_pos_r  [fwt_pkg::AXES];
  logic [C-1:0] s1_size_r [fwt_pkg::AXES];
  logic         s1_adv;
  logic         out_valid_r;
  logic         in_fire;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_found_r                   <= in_tdata[0];
      s1_pos_r[fwt_pkg::AXIS_X]    <= in_tdata[1 + 0 * C +: C];
      s1_pos_r[fwt_pkg::AXIS_Y]    <= in_tdata[1 + 1 * C +: C];
      s1_size_r[fwt_pkg::AXIS_X]   <= in_tdata[1 + 2 * C +: C];
      s1_size_r[fwt_pkg::AXIS_Y]   <= in_tdata[1 + 3 * C +: C];
    end
  end

  // --------------------------------------------------------------------------
  // Tracker state, which is also the result register
  // --------------------------------------------------------------------------
  logic         tracking_r, tracking_nxt;
  logic         moving_r,   moving_nxt;
  logic [C-1:0] shown_pos_r  [fwt_pkg::AXES];
  logic [C-1:0] shown_size_r [fwt_pkg::AXES];
  logic [C-1:0] win_pos_r    [fwt_pkg::AXES];
  logic [C-1:0] win_size_r   [fwt_pkg::AXES];
  logic [C-1:0] shown_pos_nxt  [fwt_pkg::AXES];
  logic [C-1:0] shown_size_nxt [fwt_pkg::AXES];
  logic [C-1:0] win_pos_nxt    [fwt_pkg::AXES];
  logic [C-1:0] win_size_nxt   [fwt_pkg::AXES];

  // Per-axis datapath
  logic [C:0]     abs_pos   [fwt_pkg::AXES];
  logic [C:0]     pos_diff  [fwt_pkg::AXES];
  logic [C+4:0]   pos_diff10[fwt_pkg::AXES];
  logic [C-1:0]   size_diff [fwt_pkg::AXES];
  logic [C+3:0]   size_diff10[fwt_pkg::AXES];
  logic           hold_ax   [fwt_pkg::AXES];
  logic [C-1:0]   pl_pos    [fwt_pkg::AXES];
  logic [C-1:0]   pl_size   [fwt_pkg::AXES];
  logic [2*C-1:0] div_prod  [fwt_pkg::AXES];
  logic [C-3:0]   quo5      [fwt_pkg::AXES];
  logic [2:0]     rem5      [fwt_pkg::AXES];
  logic [C-1:0]   shrink    [fwt_pkg::AXES];
  logic [C:0]     gp_raw    [fwt_pkg::AXES];
  logic [C-1:0]   gp        [fwt_pkg::AXES];
  logic [C:0]     gsize     [fwt_pkg::AXES];
  logic [C+1:0]   gsum      [fwt_pkg::AXES];
  logic           hold_all;

  always_comb begin
    for (int a = 0; a < fwt_pkg::AXES; a++) begin
      // Absolute face edge: add the window origin while tracking
      abs_pos[a] = {1'b0, s1_pos_r[a]} + (tracking_r ? {1'b0, win_pos_r[a]} : '0);

      // Ten percent band on the edge and on the size
      pos_diff[a] = (abs_pos[a] >= {1'b0, shown_pos_r[a]})
                    ? abs_pos[a] - {1'b0, shown_pos_r[a]}
                    : {1'b0, shown_pos_r[a]} - abs_pos[a];
      pos_diff10[a] = {pos_diff[a], 3'b000} + {2'b00, pos_diff[a], 1'b0};
      size_diff[a] = (s1_size_r[a] >= shown_size_r[a])
                     ? s1_size_r[a] - shown_size_r[a]
                     : shown_size_r[a] - s1_size_r[a];
      size_diff10[a] = {size_diff[a], 3'b000} + {2'b00, size_diff[a], 1'b0};
      hold_ax[a] = (pos_diff10[a] < (C+5)'(abs_pos[a])) &&
                   (size_diff10[a] < (C+4)'(s1_size_r[a]));

      // Place the shown box inside the frame
      pl_pos[a]  = (abs_pos[a] > {1'b0, lim[a]}) ? lim[a] : abs_pos[a][C-1:0];
      pl_size[a] = (({1'b0, pl_pos[a]} + {1'b0, s1_size_r[a]}) > {1'b0, lim[a]})
                   ? lim[a] - pl_pos[a] : s1_size_r[a];

      // Split size into 5*q + r by reciprocal multiplication
      div_prod[a] = (2*C)'(s1_size_r[a]) * (2*C)'(DIV5_MAGIC);
      quo5[a]     = div_prod[a][2*C-1:DIV5_SHIFT];
      rem5[a]     = 3'(s1_size_r[a] - {quo5[a], 2'b00} - C'(quo5[a]));

      // Grown edge: pos - ceil(2*size/5), floored at zero, clamped to limit
      shrink[a] = C'({quo5[a], 1'b0}) + C'(fwt_pkg::rem_ceil_2_5(rem5[a]));
      gp_raw[a] = (abs_pos[a] >= {1'b0, shrink[a]}) ? abs_pos[a] - {1'b0, shrink[a]} : '0;
      gp[a]     = (gp_raw[a] > {1'b0, lim[a]}) ? lim[a] : gp_raw[a][C-1:0];

      // Grown size: floor(9*size/5), cut at the frame edge
      gsize[a] = {quo5[a], 3'b000} + (C+1)'(quo5[a]) +
                 (C+1)'(fwt_pkg::rem_floor_9_5(rem5[a]));
      gsum[a]  = (C+2)'(gp[a]) + (C+2)'(gsize[a]);
    end
    hold_all = hold_ax[fwt_pkg::AXIS_X] && hold_ax[fwt_pkg::AXIS_Y];
  end

  // Next state for the item leaving the input register
  always_comb begin
    tracking_nxt = tracking_r;
    moving_nxt   = moving_r;
    for (int a = 0; a < fwt_pkg::AXES; a++) begin
      shown_pos_nxt[a]  = shown_pos_r[a];
      shown_size_nxt[a] = shown_size_r[a];
      win_pos_nxt[a]    = win_pos_r[a];
      win_size_nxt[a]   = win_size_r[a];
    end
    if (!s1_found_r) begin
      // Face lost: drop tracking, hold everything else
      tracking_nxt = 1'b0;
    end else begin
      tracking_nxt = 1'b1;
      moving_nxt   = tracking_r ? !hold_all : 1'b1;
      for (int a = 0; a < fwt_pkg::AXES; a++) begin
        if (!tracking_r) begin
          shown_pos_nxt[a]  = s1_pos_r[a];
          shown_size_nxt[a] = s1_size_r[a];
        end else if (!hold_all) begin
          shown_pos_nxt[a]  = pl_pos[a];
          shown_size_nxt[a] = pl_size[a];
        end
        win_pos_nxt[a]  = gp[a];
        win_size_nxt[a] = (gsum[a] > (C+2)'(lim[a])) ? lim[a] - gp[a] : gsize[a][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r <= 1'b0;
      moving_r   <= 1'b0;
      for (int a = 0; a < fwt_pkg::AXES; a++) begin
        shown_pos_r[a]  <= '0;
        shown_size_r[a] <= '0;
        win_pos_r[a]    <= '0;
        win_size_r[a]   <= '0;
      end
    end else if (s1_adv) begin
      tracking_r <= tracking_nxt;
      moving_r   <= moving_nxt;
      for (int a = 0; a < fwt_pkg::AXES; a++) begin
        shown_pos_r[a]  <= shown_pos_nxt[a];
        shown_size_r[a] <= shown_size_nxt[a];
        win_pos_r[a]    <= win_pos_nxt[a];
        win_size_r[a]   <= win_size_nxt[a];
      end
    end
  end

  // Result valid: set on compute, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result item
  // --------------------------------------------------------------------------
  logic [OUT_BITS-1:0] out_payload;

  assign out_payload = {win_size_r[fwt_pkg::AXIS_Y], win_size_r[fwt_pkg::AXIS_X],
                        win_pos_r[fwt_pkg::AXIS_Y],  win_pos_r[fwt_pkg::AXIS_X],
                        shown_size_r[fwt_pkg::AXIS_Y], shown_size_r[fwt_pkg::AXIS_X],
                        shown_pos_r[fwt_pkg::AXIS_Y],  shown_pos_r[fwt_pkg::AXIS_X],
                        moving_r, tracking_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_payload);

`ifndef ASSERT_OFF
  // A lost face always leaves tracking off
  a_lost_drops: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_adv && !s1_found_r |=> !tracking_r)
    else $error("tracking not dropped after a lost face");

  // A first detection sets both flags
  a_first_moves: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_adv && s1_found_r && !tracking_r |=> tracking_r && moving_r)
    else $error("first detection did not set tracking and moved");

  // State changes only when an item is computed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !s1_adv |=> $stable(out_payload))
    else $error("tracker state changed without an item");

  // A newly computed window lies inside the current frame
  a_win_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_found_r |->
      ({1'b0, win_pos_nxt[fwt_pkg::AXIS_X]} + {1'b0, win_size_nxt[fwt_pkg::AXIS_X]}
         <= {1'b0, lim[fwt_pkg::AXIS_X]}) &&
      ({1'b0, win_pos_nxt[fwt_pkg::AXIS_Y]} + {1'b0, win_size_nxt[fwt_pkg::AXIS_Y]}
         <= {1'b0, lim[fwt_pkg::AXIS_Y]}))
    else $error("search window outside the frame");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for face_window_tracker
// Streams detection items through the block and checks every result item
// against a predictor of the tracker state: the tracking flag, the ten percent
// band, the shown box and the clamped search window. Runs over several frame
// sizes, degenerate ones included, with random idling on both sides and one
// long output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB           = fwt_pkg::COORD_BITS_DEF;
  localparam int FB           = fwt_pkg::FRAME_BITS;
  localparam int IN_BITS      = 1 + 4 * CB;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 2 + 8 * CB;
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_STALL   = 400;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 210;
  localparam int DRAIN_CYCLES = 6;
  localparam longint COORD_TOP = (longint'(1) << CB) - 1;

  // Detection item, face_found in the lowest bit
  typedef struct packed {
    logic [CB-1:0] h;
    logic [CB-1:0] w;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
    logic          found;
  } detection_t;

  // Result item, tracking in the lowest bit
  typedef struct packed {
    logic [CB-1:0] win_h;
    logic [CB-1:0] win_w;
    logic [CB-1:0] win_y;
    logic [CB-1:0] win_x;
    logic [CB-1:0] shown_h;
    logic [CB-1:0] shown_w;
    logic [CB-1:0] shown_y;
    logic [CB-1:0] shown_x;
    logic          moved;
    logic          tracking;
  } track_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [fwt_pkg::CFG_IDX_BITS-1:0] cfg_index = fwt_pkg::CFG_FRAME_WIDTH;
  logic [FB-1:0]                    cfg_wdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // face_found, face_x, face_y, face_w, face_h (low to high), zero padded
  logic [IN_W-1:0]                  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // tracking, moved, shown_x, shown_y, shown_w, shown_h,
  // window_x, window_y, window_w, window_h (low to high), zero padded
  logic [OUT_W-1:0]                 out_tdata;

  face_window_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  detection_t    detections_q[$];
  track_result_t track_results_q[$];
  detection_t    held_detection;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic          stall_req = 1'b0;
  int            cycle_count = 0;

  // Tracker state as the block should hold it
  logic [FB-1:0] frame_w_now = fwt_pkg::FRAME_WIDTH_RST;
  logic [FB-1:0] frame_h_now = fwt_pkg::FRAME_HEIGHT_RST;
  bit            tracking_now = 1'b0;
  bit            moving_now = 1'b0;
  longint        shown_box[4] = '{0, 0, 0, 0};
  longint        search_win[4] = '{0, 0, 0, 0};

  // Last valid coordinate for a frame size, saturated to the coordinate range
  function automatic longint axis_limit(logic [FB-1:0] size);
    longint l;
    l = (size == 0) ? 0 : longint'(size) - 1;
    if (l > COORD_TOP) l = COORD_TOP;
    return l;
  endfunction

  // A zero face value never holds, so it counts as moved
  function automatic bit in_band(longint a, longint s);
    longint d;
    d = a - s;
    if (d < 0) d = -d;
    return (10 * d) < a;
  endfunction

  // Grow the face by 0.4 of its size on each side, then clamp to the frame
  function automatic void grow_axis(input longint pos, input longint size,
                                    input longint off, input longint lim,
                                    output longint np, output longint ns);
    longint p;
    longint s;
    p = (5 * (pos + off) - 2 * size) / 5;
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    s = (9 * size) / 5;
    if (p + s > lim) s = lim - p;
    np = p;
    ns = s;
  endfunction

  function automatic void place_axis(input longint pos, input longint size,
                                     input longint lim,
                                     output longint np, output longint ns);
    longint p;
    longint s;
    p = pos;
    s = size;
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    if (p + s > lim) s = lim - p;
    np = p;
    ns = s;
  endfunction

  // Advance the tracker by one detection and return the result it must give
  function automatic track_result_t track_frame(detection_t d);
    longint        fx;
    longint        fy;
    longint        fw;
    longint        fh;
    longint        lx;
    longint        ly;
    longint        ox;
    longint        oy;
    bit            hold;
    track_result_t r;
    fx = d.x;
    fy = d.y;
    fw = d.w;
    fh = d.h;
    lx = axis_limit(frame_w_now);
    ly = axis_limit(frame_h_now);
    if (!d.found) begin
      tracking_now = 1'b0;
    end else if (tracking_now) begin
      ox = search_win[0];
      oy = search_win[1];
      hold = in_band(fx + ox, shown_box[0]) && in_band(fy + oy, shown_box[1]) &&
             in_band(fw, shown_box[2]) && in_band(fh, shown_box[3]);
      if (!hold) begin
        place_axis(fx + ox, fw, lx, shown_box[0], shown_box[2]);
        place_axis(fy + oy, fh, ly, shown_box[1], shown_box[3]);
      end
      moving_now = !hold;
      grow_axis(fx, fw, ox, lx, search_win[0], search_win[2]);
      grow_axis(fy, fh, oy, ly, search_win[1], search_win[3]);
    end else begin
      tracking_now = 1'b1;
      moving_now = 1'b1;
      shown_box[0] = fx;
      shown_box[1] = fy;
      shown_box[2] = fw;
      shown_box[3] = fh;
      grow_axis(fx, fw, 0, lx, search_win[0], search_win[2]);
      grow_axis(fy, fh, 0, ly, search_win[1], search_win[3]);
    end
    r.tracking = tracking_now;
    r.moved    = moving_now;
    r.shown_x  = CB'(shown_box[0]);
    r.shown_y  = CB'(shown_box[1]);
    r.shown_w  = CB'(shown_box[2]);
    r.shown_h  = CB'(shown_box[3]);
    r.win_x    = CB'(search_win[0]);
    r.win_y    = CB'(search_win[1]);
    r.win_w    = CB'(search_win[2]);
    r.win_h    = CB'(search_win[3]);
    return r;
  endfunction

  // Driver: predict each accepted item, then offer the next one or idle
  always @(posedge clk) begin : detection_driver
    logic fire;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) track_results_q.push_back(track_frame(held_detection));
      if (!in_tvalid || fire) begin
        if (detections_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_detection = detections_q.pop_front();
          in_tdata  <= {{(IN_W - IN_BITS){1'b0}}, held_detection};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin : result_receiver
    int   stall_left;
    logic stall_taken;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      stall_left  = 0;
      stall_taken = 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_left  = LONG_STALL;
      stall_taken = 1'b1;
      out_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_monitor
    track_result_t got;
    track_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_BITS-1:0];
      if (track_results_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = track_results_q.pop_front();
        check_field("tracking", want.tracking, got.tracking);
        check_field("moved", want.moved, got.moved);
        check_field("shown_x", want.shown_x, got.shown_x);
        check_field("shown_y", want.shown_y, got.shown_y);
        check_field("shown_w", want.shown_w, got.shown_w);
        check_field("shown_h", want.shown_h, got.shown_h);
        check_field("window_x", want.win_x, got.win_x);
        check_field("window_y", want.win_y, got.win_y);
        check_field("window_w", want.win_w, got.win_w);
        check_field("window_h", want.win_h, got.win_h);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("face_window_tracker test failed");
      $finish;
    end
  end

  function automatic logic [CB-1:0] clip_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_TOP) return CB'(COORD_TOP);
    return CB'(v);
  endfunction

  function automatic detection_t make_detection(bit found, int x, int y, int w, int h);
    detection_t d;
    d.found = found;
    d.x = clip_coord(x);
    d.y = clip_coord(y);
    d.w = clip_coord(w);
    d.h = clip_coord(h);
    return d;
  endfunction

  function automatic int jitter(int m);
    int v;
    v = $urandom_range(0, 2 * m);
    return v - m;
  endfunction

  function automatic detection_t lost_detection();
    return make_detection(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
  endfunction

  // Queue tracking runs: a first detection, then window-relative faces that
  // mostly stay inside the band, sometimes jump, then usually a lost frame.
  // Mix in raw noise items.
  task automatic queue_random(int n);
    int          left;
    int          run_len;
    int          w;
    int          h;
    int          px;
    int          py;
    logic [63:0] raw;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        raw = {$urandom, $urandom};
        detections_q.push_back(raw[IN_BITS-1:0]);
        left--;
      end else begin
        run_len = $urandom_range(2, 24);
        if ($urandom_range(9) == 0) begin
          w = $urandom_range(0, 4095);
          h = $urandom_range(0, 4095);
        end else begin
          w = $urandom_range(4, 160);
          h = $urandom_range(4, 160);
        end
        if ($urandom_range(1) != 0) begin
          px = $urandom_range(0, 4095);
          py = $urandom_range(0, 4095);
        end else begin
          px = $urandom_range(0, 700);
          py = $urandom_range(0, 520);
        end
        detections_q.push_back(make_detection(1'b1, px, py, w, h));
        left--;
        for (int k = 1; k < run_len && left > 0; k++) begin
          if ($urandom_range(4) == 0) begin
            w = w + jitter(w / 3 + 1);
            h = h + jitter(h / 3 + 1);
          end else begin
            w = w + jitter(w / 30);
            h = h + jitter(h / 30);
          end
          w = int'(clip_coord(w));
          h = int'(clip_coord(h));
          if ($urandom_range(19) == 0) begin
            detections_q.push_back(lost_detection());
          end else begin
            detections_q.push_back(make_detection(1'b1,
              (2 * w) / 5 + jitter(w / 12 + 1), (2 * h) / 5 + jitter(h / 12 + 1), w, h));
          end
          left--;
        end
        if ($urandom_range(3) != 0 && left > 0) begin
          detections_q.push_back(lost_detection());
          left--;
        end
      end
    end
  endtask

  task automatic queue_directed();
    // lost at reset, first detection, hold, small jitter, move, zero width
    detections_q.push_back(make_detection(1'b0, 0, 0, 0, 0));
    detections_q.push_back(make_detection(1'b1, 100, 80, 50, 60));
    detections_q.push_back(make_detection(1'b1, 20, 24, 50, 60));
    detections_q.push_back(make_detection(1'b1, 21, 25, 52, 61));
    detections_q.push_back(make_detection(1'b1, 40, 24, 50, 60));
    detections_q.push_back(make_detection(1'b1, 20, 24, 0, 60));
    detections_q.push_back(make_detection(1'b1, 0, 0, 30, 30));
    // field extremes while tracking, lost and on first detection
    detections_q.push_back(make_detection(1'b1, 4095, 4095, 4095, 4095));
    detections_q.push_back(make_detection(1'b0, 4095, 4095, 4095, 4095));
    detections_q.push_back(make_detection(1'b1, 4095, 4095, 4095, 4095));
    detections_q.push_back(make_detection(1'b1, 0, 0, 0, 0));
    detections_q.push_back(make_detection(1'b0, 0, 0, 0, 0));
    detections_q.push_back(make_detection(1'b1, 0, 0, 0, 0));
    detections_q.push_back(make_detection(1'b1, 0, 0, 0, 0));
    // alternating bit patterns
    detections_q.push_back(make_detection(1'b1, 2730, 1365, 2730, 1365));
    detections_q.push_back(make_detection(1'b1, 1365, 2730, 1365, 2730));
    detections_q.push_back(make_detection(1'b0, 1365, 2730, 1365, 2730));
    // faces at the frame edge, clamped window and shown box
    detections_q.push_back(make_detection(1'b1, 630, 470, 20, 20));
    detections_q.push_back(make_detection(1'b1, 8, 8, 20, 20));
    detections_q.push_back(make_detection(1'b1, 600, 400, 300, 300));
    detections_q.push_back(make_detection(1'b0, 0, 0, 0, 0));
  endtask

  // Register writes happen only with the block idle
  task automatic write_frame(fwt_pkg::cfg_idx_t idx, logic [FB-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == fwt_pkg::CFG_FRAME_WIDTH) frame_w_now = val;
    else frame_h_now = val;
  endtask

  task automatic wait_drained();
    while (detections_q.size() != 0 || in_tvalid || track_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: one phase per frame size setting
  initial begin : stimulus
    logic [FB-1:0] fw_set;
    logic [FB-1:0] fh_set;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        case (p)
          1: begin fw_set = 13'd2;    fh_set = 13'd2;    end
          2: begin fw_set = 13'd4096; fh_set = 13'd4096; end
          3: begin fw_set = 13'd0;    fh_set = 13'd8191; end
          4: begin fw_set = 13'd8191; fh_set = 13'd1;    end
          5: begin
            fw_set = FB'($urandom_range(2, 4096));
            fh_set = FB'($urandom_range(2, 4096));
          end
          default: begin
            fw_set = fwt_pkg::FRAME_WIDTH_RST;
            fh_set = fwt_pkg::FRAME_HEIGHT_RST;
          end
        endcase
        write_frame(fwt_pkg::CFG_FRAME_WIDTH, fw_set);
        write_frame(fwt_pkg::CFG_FRAME_HEIGHT, fh_set);
      end
      @(posedge clk);
      // sender idles rarely first, then the receiver, then neither
      if (p < 3) begin
        send_idle_pct <= 7;
        recv_idle_pct <= 64;
      end else if (p < 5) begin
        send_idle_pct <= 64;
        recv_idle_pct <= 7;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (p == 0) queue_directed();
      queue_random(PHASE_ITEMS);
      if (p == 5) begin
        @(posedge clk);
        stall_req <= 1'b1;
      end
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("face_window_tracker test passed");
    end else begin
      $display("face_window_tracker test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fwt_pkg.sv
hw/rtl/face_window_tracker.sv
dv/testbench.sv
